@@ rtl/core/rse_pkg.sv @@
// Package for the radix symbol encoder: field types, divider interface, alphabet and radix helpers.
package rse_pkg;

	localparam int VALUE_WIDTH   = 31;
	localparam int RADIX_W       = 5;
	localparam int LETTER_W      = 8;
	localparam int ALPHABET_SIZE = 26;
	localparam int RADIX_MIN     = 2;
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(4);

	localparam int DIV_BITS  = 4;
	localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W     = DIV_STEPS * DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [RADIX_W-1:0]     radix_t;
	typedef logic [LETTER_W-1:0]    letter_t;

	typedef struct packed {
		value_t value;
		value_t max_value;
	} item_t;

	typedef struct packed {
		radix_t  digit;
		letter_t letter;
		logic    last;
		logic    error;
	} result_t;

	typedef struct packed {
		logic   start;
		value_t dividend_a;
		value_t dividend_b;
		radix_t divisor;
	} div_req_t;

	typedef struct packed {
		logic   busy;
		logic   done;
		value_t quotient_a;
		radix_t remainder_a;
		value_t quotient_b;
	} div_rsp_t;

	localparam letter_t ALPHABET [ALPHABET_SIZE] = '{
		8'h41, 8'h54, 8'h43, 8'h47, 8'h45, 8'h46, 8'h44, 8'h48, 8'h49,
		8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
		8'h53, 8'h42, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A
	};

	function automatic letter_t letter_of(input radix_t d);
		letter_t l;
		l = '0;
		if (d < RADIX_W'(ALPHABET_SIZE)) begin
			l = ALPHABET[d];
		end
		return l;
	endfunction

	function automatic radix_t effective_radix(input radix_t raw);
		radix_t r;
		r = raw;
		if (r < RADIX_W'(RADIX_MIN)) begin
			r = RADIX_W'(RADIX_MIN);
		end
		if (r > RADIX_W'(ALPHABET_SIZE)) begin
			r = RADIX_W'(ALPHABET_SIZE);
		end
		return r;
	endfunction

endpackage

@@ rtl/core/rse_div.sv @@
// Shared two-lane iterative divider by a small radix, several quotient bits per cycle.
module rse_div import rse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = RADIX_W + DIV_BITS;

	function automatic logic [STEP_W-1:0] div_step(
		input radix_t              rem_in,
		input logic [DIV_BITS-1:0] bits,
		input radix_t              divisor
	);
		radix_t              r;
		logic [RADIX_W:0]    t;
		logic [DIV_BITS-1:0] q;
		r = rem_in;
		q = '0;
		for (int k = DIV_BITS - 1; k >= 0; k--) begin
			t = {r, bits[k]};
			if (t >= {1'b0, divisor}) begin
				t    = t - {1'b0, divisor};
				q[k] = 1'b1;
			end
			r = t[RADIX_W-1:0];
		end
		return {r, q};
	endfunction

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     acc_a_q;
	logic [DIV_W-1:0]     acc_b_q;
	radix_t               rem_a_q;
	radix_t               rem_b_q;
	radix_t               divisor_q;
	logic [STEP_W-1:0]    step_a;
	logic [STEP_W-1:0]    step_b;

	always_comb begin
		step_a = div_step(rem_a_q, acc_a_q[DIV_W-1 -: DIV_BITS], divisor_q);
		step_b = div_step(rem_b_q, acc_b_q[DIV_W-1 -: DIV_BITS], divisor_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_a_q   <= DIV_W'(req.dividend_a);
			acc_b_q   <= DIV_W'(req.dividend_b);
			rem_a_q   <= '0;
			rem_b_q   <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			acc_a_q <= {acc_a_q[DIV_W-DIV_BITS-1:0], step_a[DIV_BITS-1:0]};
			acc_b_q <= {acc_b_q[DIV_W-DIV_BITS-1:0], step_b[DIV_BITS-1:0]};
			rem_a_q <= step_a[STEP_W-1:DIV_BITS];
			rem_b_q <= step_b[STEP_W-1:DIV_BITS];
		end
	end

	assign rsp.busy        = busy_q;
	assign rsp.done        = done_q;
	assign rsp.quotient_a  = acc_a_q[VALUE_WIDTH-1:0];
	assign rsp.remainder_a = rem_a_q;
	assign rsp.quotient_b  = acc_b_q[VALUE_WIDTH-1:0];

endmodule

@@ rtl/core/radix_symbol_encoder_core.sv @@
// Top level of the radix symbol encoder: digit sequencer, radix register and result register.
//
//  channel | handshake              | beat
//  item    | item_valid, item_stall | value and max_value of one number
//  result  | result_valid, result_stall | one digit with its letter, or one error
//  cfg     | cfg_valid, cfg_ready   | new radix register value
//
// For each digit the shared divider runs its DIV_STEPS steps, the sequencer then captures the
// quotients and the remainder, and the emit state loads the result register.
// The divider runs value and maximum side by side; the digit is last once the maximum reaches zero.
// Reset clears the sequencer and sets the radix to 4; a new item is taken only when idle.
// A stalled result holds the sequencer in its emit state until the beat is taken.
module radix_symbol_encoder_core import rse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  radix_t  cfg_radix
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WAIT,
		S_EMIT
	} state_t;

	state_t   state_q;
	radix_t   radix_q;
	radix_t   eff_radix;
	logic     err_q;
	logic     last_q;
	radix_t   digit_q;
	value_t   val_q;
	value_t   max_q;
	logic     result_valid_q;
	result_t  result_q;
	logic     item_take;
	logic     over;
	logic     out_free;
	logic     emit;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;
	assign eff_radix = effective_radix(radix_q);

	assign item_stall = (state_q != S_IDLE);
	assign item_take  = item_valid && !item_stall;
	assign over       = item.value > item.max_value;
	assign out_free   = !result_valid_q || !result_stall;
	assign emit       = (state_q == S_EMIT) && out_free;

	assign div_req.start      = (item_take && !over) || (emit && !last_q);
	assign div_req.dividend_a = (state_q == S_IDLE) ? item.value : val_q;
	assign div_req.dividend_b = (state_q == S_IDLE) ? item.max_value : max_q;
	assign div_req.divisor    = eff_radix;

	rse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q        <= RADIX_RESET;
			state_q        <= S_IDLE;
			err_q          <= 1'b0;
			last_q         <= 1'b0;
			digit_q        <= '0;
			val_q          <= '0;
			max_q          <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				radix_q <= cfg_radix;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_take) begin
						if (over) begin
							err_q   <= 1'b1;
							last_q  <= 1'b1;
							state_q <= S_EMIT;
						end else begin
							err_q   <= 1'b0;
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					if (div_rsp.done) begin
						last_q  <= (div_rsp.quotient_b == '0);
						digit_q <= div_rsp.remainder_a;
						val_q   <= div_rsp.quotient_a;
						max_q   <= div_rsp.quotient_b;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= last_q ? S_IDLE : S_WAIT;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (emit) begin
				result_valid_q  <= 1'b1;
				result_q.digit  <= err_q ? '0 : digit_q;
				result_q.letter <= err_q ? '0 : letter_of(digit_q);
				result_q.last   <= last_q;
				result_q.error  <= err_q;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error |-> result.last)
		else $error("error beat without last");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_WAIT)
		else $error("divider result arrived outside the wait state");

	a_digit_in_radix: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.error |-> result.digit < eff_radix)
		else $error("digit not below the radix");

endmodule

@@ tb/tb_radix_symbol_encoder_core.sv @@
// Self-checking testbench for the radix symbol encoder core with random traffic and back-pressure.
`timescale 1ns / 1ps

module tb_radix_symbol_encoder_core;
	import rse_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 40;
	localparam int REPORT_LIMIT  = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 28;
	localparam value_t FULL_SCALE = '1;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	logic    cfg_valid = 1'b0;
	logic    cfg_ready;
	radix_t  cfg_radix = '0;

	string   symbols = "ATCGEFDHIJKLMNOPQRSBUVWXYZ";
	result_t pending_digits[$];
	radix_t  radix_setting = RADIX_RESET;
	int      mismatch_count = 0;
	int      cycle_count = 0;
	bit      sender_idles = 1'b1;
	bit      receiver_idles = 1'b1;
	int      stall_left = 0;
	int      hold_left = 0;

	radix_symbol_encoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_radix    (cfg_radix)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Works out the digit beats of one number at the radix currently programmed.
	function automatic void encode_number(input value_t v, input value_t m);
		radix_t          r;
		int unsigned     base;
		longint unsigned span;
		int              places;
		value_t          q;
		result_t         beat;
		r = radix_setting;
		if (r < 5'd2) begin
			r = 5'd2;
		end
		if (r > 5'd26) begin
			r = 5'd26;
		end
		base = r;
		if (v > m) begin
			beat.digit = '0;
			beat.letter = '0;
			beat.last = 1'b1;
			beat.error = 1'b1;
			pending_digits.push_back(beat);
			return;
		end
		span = base;
		places = 1;
		while (span <= m) begin
			span = span * base;
			places++;
		end
		q = v;
		for (int i = 0; i < places; i++) begin
			beat.digit = radix_t'(q % base);
			beat.letter = letter_t'(symbols.getc(int'(beat.digit)));
			beat.last = (i == places - 1);
			beat.error = 1'b0;
			pending_digits.push_back(beat);
			q = value_t'(q / base);
		end
	endfunction

	// Result side: checks every accepted beat and drives the stall pattern.
	initial begin
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid === 1'b1 && !result_stall) begin
				if (pending_digits.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("unexpected result beat: digit %0d letter %h last %b error %b",
							result.digit, result.letter, result.last, result.error);
					end
				end else begin
					want = pending_digits.pop_front();
					if (result.digit !== want.digit || result.letter !== want.letter ||
						result.last !== want.last || result.error !== want.error) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("result mismatch: expected digit %0d letter %h",
								want.digit, want.letter,
								" last %b error %b,", want.last, want.error,
								" got digit %0d letter %h", result.digit, result.letter,
								" last %b error %b", result.last, result.error);
						end
					end
				end
				stall_left = receiver_idles ? $urandom_range(5, 0) : 0;
			end
			@(negedge clk);
			if (hold_left > 0) begin
				result_stall = 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				result_stall = 1'b1;
				stall_left--;
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	task automatic send_number(input value_t v, input value_t m);
		int gap;
		gap = sender_idles ? $urandom_range(5, 0) : 0;
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.value = v;
		item.max_value = m;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall !== 1'b0) @(posedge clk);
		encode_number(v, m);
		@(negedge clk);
	endtask

	task automatic send_random_number;
		value_t      m;
		value_t      v;
		int unsigned width_bits;
		width_bits = $urandom_range(31, 0);
		m = value_t'(((32'd1 << width_bits) - 32'd1) & $urandom);
		if ($urandom_range(9, 0) == 0) begin
			m = FULL_SCALE;
		end
		case ($urandom_range(19, 0))
			0, 1, 2: begin
				if (m == FULL_SCALE) begin
					v = m;
				end else begin
					v = value_t'($urandom_range(32'h7FFF_FFFF, {1'b0, m} + 32'd1));
				end
			end
			3: v = m;
			4: v = '0;
			default: v = value_t'($urandom_range({1'b0, m}, 0));
		endcase
		send_number(v, m);
	endtask

	task automatic wait_idle;
		item_valid = 1'b0;
		while (pending_digits.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_radix(input radix_t r);
		wait_idle();
		cfg_radix = r;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		radix_setting = r;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_reset_radix;
		send_number('0, '0);
		send_number('0, FULL_SCALE);
		send_number(FULL_SCALE, FULL_SCALE);
		send_number(31'd15, 31'd15);
		send_number(31'd16, 31'd16);
		send_number(31'd4, 31'd15);
		send_number(31'd5, 31'd4);
		send_number(FULL_SCALE, '0);
		send_number(31'd1, '0);
		wait_idle();
	endtask

	task automatic test_radix_clamping;
		set_radix(5'd0);
		send_number(FULL_SCALE, FULL_SCALE);
		send_number(31'h2AAA_AAAA, FULL_SCALE);
		set_radix(5'd1);
		send_number(31'h5555_5555, FULL_SCALE);
		set_radix(5'd31);
		send_number(31'd12345678, FULL_SCALE);
		set_radix(5'd27);
		send_number(31'd25, 31'd25);
		send_number(FULL_SCALE, FULL_SCALE);
		set_radix(5'd26);
		send_number(31'd308915775, 31'd308915775);
		set_radix(5'd2);
		send_number('0, '0);
		send_number(31'd1, 31'd1);
		wait_idle();
	endtask

	task automatic test_random_phases;
		radix_t phase_radix [7];
		phase_radix = '{5'd3, 5'd26, 5'd2, 5'd7, 5'd16, 5'd31, 5'd0};
		for (int p = 0; p < 7; p++) begin
			set_radix(p == 3 ? radix_t'($urandom_range(31, 0)) : phase_radix[p]);
			sender_idles = (p != 4);
			receiver_idles = (p != 4);
			repeat (PHASE_ITEMS) send_random_number();
		end
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		wait_idle();
	endtask

	task automatic test_back_pressure;
		set_radix(5'd10);
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		repeat (4) send_random_number();
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		wait_idle();
	endtask

	task automatic test_sender_pause;
		set_radix(5'd5);
		repeat (6) send_random_number();
		wait_idle();
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		repeat (6) send_random_number();
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		wait_idle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_radix();
		test_radix_clamping();
		test_random_phases();
		test_back_pressure();
		test_sender_pause();
		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && pending_digits.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
